/* hdl/source_text_tokenizer_macros.svh */
// Assertion macros shared by the source text tokenizer RTL
`ifndef SOURCE_TEXT_TOKENIZER_MACROS_SVH
`define SOURCE_TEXT_TOKENIZER_MACROS_SVH
`ifndef SYNTH
`define STT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tokenizer check failed");
`define STT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tokenizer check failed");
`else
`define STT_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define STT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/stt_pkg.sv */
// Types and constants shared by the source text tokenizer modules
package stt_pkg;

  typedef logic [4:0]  kind_t;
  typedef logic [31:0] start_t;
  typedef logic [15:0] len_t;
  typedef logic [23:0] line_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    kind_t  token_kind;
    start_t token_start;
    len_t   token_length;
    line_t  line_number;
    logic   last_of_run;
  } out_item_t;

  // One queue entry holds every result of one input byte
  typedef struct packed {
    logic      two;
    out_item_t res0;
    out_item_t res1;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam kind_t KIND_INT    = 5'd0;
  localparam kind_t KIND_FLOAT  = 5'd1;
  localparam kind_t KIND_IDENT  = 5'd2;
  localparam kind_t KIND_PLUS   = 5'd3;
  localparam kind_t KIND_MINUS  = 5'd4;
  localparam kind_t KIND_STAR   = 5'd5;
  localparam kind_t KIND_SLASH  = 5'd6;
  localparam kind_t KIND_EQUAL  = 5'd7;
  localparam kind_t KIND_LPAREN = 5'd8;
  localparam kind_t KIND_RPAREN = 5'd9;
  localparam kind_t KIND_LBRACE = 5'd10;
  localparam kind_t KIND_RBRACE = 5'd11;
  localparam kind_t KIND_PERIOD = 5'd12;
  localparam kind_t KIND_COMMA  = 5'd13;
  localparam kind_t KIND_COLON  = 5'd14;
  localparam kind_t KIND_SEMI   = 5'd15;
  localparam kind_t KIND_END    = 5'd16;
  localparam kind_t KIND_ERROR  = 5'd17;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_LOW_A   = 8'h61;
  localparam logic [7:0] CH_LOW_Z   = 8'h7A;
  localparam logic [7:0] CH_UP_A    = 8'h41;
  localparam logic [7:0] CH_UP_Z    = 8'h5A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_PERIOD  = 8'h2E;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_SEMI    = 8'h3B;

endpackage

/* hdl/stt_front.sv */
// Front end: classify each byte, track scan state, build queue entries
module stt_front #(
  parameter int OFFSET_BITS = 32,
  parameter int LENGTH_BITS = 16,
  parameter int LINE_BITS   = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  stt_pkg::in_item_t in_item,
  input  stt_pkg::q_stat_t  q_stat,
  output logic              push,
  output stt_pkg::q_entry_t push_entry
);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_NUMBER,
    MODE_IDENT,
    MODE_HALTED
  } mode_t;

  typedef enum logic [2:0] {
    CLS_LETTER,
    CLS_DIGIT,
    CLS_SPACE,
    CLS_NEWLINE,
    CLS_PUNCT,
    CLS_ILLEGAL
  } cls_t;

  localparam logic [OFFSET_BITS-1:0] OFF_ONE  = OFFSET_BITS'(1);
  localparam logic [LENGTH_BITS-1:0] LEN_ONE  = LENGTH_BITS'(1);
  localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);

  mode_t                   mode_r, mode_nxt;
  logic                    saw_period_r, saw_period_nxt;
  logic [OFFSET_BITS-1:0]  pend_start_r, pend_start_nxt;
  logic [LENGTH_BITS-1:0]  pend_len_r, pend_len_nxt;
  logic [LINE_BITS-1:0]    line_r, line_nxt;
  logic [OFFSET_BITS-1:0]  offset_r, offset_nxt;

  cls_t               cls;
  stt_pkg::kind_t     punct_kind;
  logic               accept;
  logic               do_flush;
  logic               flush_vld;
  logic               sec_vld;
  stt_pkg::out_item_t flush_tok;
  stt_pkg::out_item_t sec_tok;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cls        = CLS_ILLEGAL;
    punct_kind = stt_pkg::KIND_ERROR;
    case (in_item.in_byte) inside
      stt_pkg::CH_SPACE, stt_pkg::CH_TAB: cls = CLS_SPACE;
      stt_pkg::CH_NEWLINE: cls = CLS_NEWLINE;
      [stt_pkg::CH_LOW_A:stt_pkg::CH_LOW_Z], [stt_pkg::CH_UP_A:stt_pkg::CH_UP_Z]:
        cls = CLS_LETTER;
      [stt_pkg::CH_ZERO:stt_pkg::CH_NINE]: cls = CLS_DIGIT;
      stt_pkg::CH_PLUS: begin
        cls = CLS_PUNCT; punct_kind = stt_pkg::KIND_PLUS;
      end
      stt_pkg::CH_MINUS: begin
        cls = CLS_PUNCT; punct_kind = stt_pkg::KIND_MINUS;
      end
      stt_pkg::CH_STAR: begin
        cls = CLS_PUNCT; punct_kind = stt_pkg::KIND_STAR;
      end
      stt_pkg::CH_SLASH: begin
        cls = CLS_PUNCT; punct_kind = stt_pkg::KIND_SLASH;
      end
      stt_pkg::CH_EQUAL: begin
        cls = CLS_PUNCT; punct_kind = stt_pkg::KIND_EQUAL;
      end
      stt_pkg::CH_LPAREN: begin
        cls = CLS_PUNCT; punct_kind = stt_pkg::KIND_LPAREN;
      end
      stt_pkg::CH_RPAREN: begin
        cls = CLS_PUNCT; punct_kind = stt_pkg::KIND_RPAREN;
      end
      stt_pkg::CH_LBRACE: begin
        cls = CLS_PUNCT; punct_kind = stt_pkg::KIND_LBRACE;
      end
      stt_pkg::CH_RBRACE: begin
        cls = CLS_PUNCT; punct_kind = stt_pkg::KIND_RBRACE;
      end
      stt_pkg::CH_PERIOD: begin
        cls = CLS_PUNCT; punct_kind = stt_pkg::KIND_PERIOD;
      end
      stt_pkg::CH_COMMA: begin
        cls = CLS_PUNCT; punct_kind = stt_pkg::KIND_COMMA;
      end
      stt_pkg::CH_COLON: begin
        cls = CLS_PUNCT; punct_kind = stt_pkg::KIND_COLON;
      end
      stt_pkg::CH_SEMI: begin
        cls = CLS_PUNCT; punct_kind = stt_pkg::KIND_SEMI;
      end
      default: cls = CLS_ILLEGAL;
    endcase
  end

  // Token that a flush would report, taken from the state before this byte
  always_comb begin
    flush_tok.token_kind   = (mode_r == MODE_IDENT) ? stt_pkg::KIND_IDENT :
                             (saw_period_r ? stt_pkg::KIND_FLOAT : stt_pkg::KIND_INT);
    flush_tok.token_start  = stt_pkg::start_t'(pend_start_r);
    flush_tok.token_length = stt_pkg::len_t'(pend_len_r);
    flush_tok.line_number  = stt_pkg::line_t'(line_r);
    flush_tok.last_of_run  = 1'b0;
  end

  always_comb begin
    mode_nxt       = mode_r;
    saw_period_nxt = saw_period_r;
    pend_start_nxt = pend_start_r;
    pend_len_nxt   = pend_len_r;
    line_nxt       = line_r;
    offset_nxt     = offset_r + OFF_ONE;
    do_flush       = 1'b0;
    sec_vld        = 1'b0;
    sec_tok.token_kind   = punct_kind;
    sec_tok.token_start  = stt_pkg::start_t'(offset_r);
    sec_tok.token_length = stt_pkg::len_t'(1);
    sec_tok.line_number  = stt_pkg::line_t'(line_r);
    sec_tok.last_of_run  = 1'b1;

    if (in_item.end_of_text) begin
      do_flush             = (mode_r != MODE_HALTED);
      sec_vld              = 1'b1;
      sec_tok.token_kind   = stt_pkg::KIND_END;
      sec_tok.token_length = '0;
      mode_nxt       = MODE_IDLE;
      saw_period_nxt = 1'b0;
      pend_start_nxt = '0;
      pend_len_nxt   = '0;
      line_nxt       = LINE_ONE;
      offset_nxt     = '0;
    end else if (mode_r != MODE_HALTED) begin
      case (cls)
        CLS_LETTER: begin
          if (mode_r == MODE_IDENT) begin
            if (pend_len_r != '1) pend_len_nxt = pend_len_r + LEN_ONE;
          end else begin
            do_flush       = 1'b1;
            mode_nxt       = MODE_IDENT;
            saw_period_nxt = 1'b0;
            pend_start_nxt = offset_r;
            pend_len_nxt   = LEN_ONE;
          end
        end
        CLS_DIGIT: begin
          if (mode_r == MODE_IDENT || mode_r == MODE_NUMBER) begin
            if (pend_len_r != '1) pend_len_nxt = pend_len_r + LEN_ONE;
          end else begin
            mode_nxt       = MODE_NUMBER;
            saw_period_nxt = 1'b0;
            pend_start_nxt = offset_r;
            pend_len_nxt   = LEN_ONE;
          end
        end
        CLS_SPACE, CLS_NEWLINE: begin
          do_flush       = 1'b1;
          mode_nxt       = MODE_IDLE;
          saw_period_nxt = 1'b0;
          pend_len_nxt   = '0;
          if (cls == CLS_NEWLINE && line_r != '1) line_nxt = line_r + LINE_ONE;
        end
        CLS_PUNCT: begin
          if (punct_kind == stt_pkg::KIND_PERIOD && mode_r == MODE_NUMBER) begin
            // Period inside a number extends it and makes it a float
            if (pend_len_r != '1) pend_len_nxt = pend_len_r + LEN_ONE;
            saw_period_nxt = 1'b1;
          end else begin
            do_flush       = 1'b1;
            sec_vld        = 1'b1;
            mode_nxt       = MODE_IDLE;
            saw_period_nxt = 1'b0;
            pend_len_nxt   = '0;
          end
        end
        default: begin
          // Illegal byte: flush, report, halt until end of text
          do_flush           = 1'b1;
          sec_vld            = 1'b1;
          sec_tok.token_kind = stt_pkg::KIND_ERROR;
          mode_nxt           = MODE_HALTED;
          saw_period_nxt     = 1'b0;
          pend_len_nxt       = '0;
        end
      endcase
    end
  end

  assign flush_vld = do_flush && (mode_r == MODE_NUMBER || mode_r == MODE_IDENT);

  always_comb begin
    push_entry.two  = flush_vld && sec_vld;
    push_entry.res0 = flush_vld ? flush_tok : sec_tok;
    push_entry.res0.last_of_run = !(flush_vld && sec_vld);
    push_entry.res1 = sec_tok;
  end

  assign push = accept && (flush_vld || sec_vld);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_IDLE;
      saw_period_r <= 1'b0;
      pend_start_r <= '0;
      pend_len_r   <= '0;
      line_r       <= LINE_ONE;
      offset_r     <= '0;
    end else if (accept) begin
      mode_r       <= mode_nxt;
      saw_period_r <= saw_period_nxt;
      pend_start_r <= pend_start_nxt;
      pend_len_r   <= pend_len_nxt;
      line_r       <= line_nxt;
      offset_r     <= offset_nxt;
    end
  end

endmodule

/* hdl/stt_queue.sv */
// Short register queue between the front and back ends
module stt_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  stt_pkg::q_entry_t push_entry,
  input  logic              pop,
  output stt_pkg::q_entry_t head,
  output stt_pkg::q_stat_t  q_stat
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PTR_LAST = PtrW'(DEPTH - 1);
  localparam logic [PtrW-1:0] PTR_ONE  = PtrW'(1);
  localparam logic [CntW-1:0] CNT_ONE  = CntW'(1);
  localparam logic [CntW-1:0] CNT_FULL = CntW'(DEPTH);

  stt_pkg::q_entry_t entries_r [DEPTH];
  logic [PtrW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]   count_r, count_nxt;

  always_comb begin
    case ({push, pop})
      2'b10:   count_nxt = count_r + CNT_ONE;
      2'b01:   count_nxt = count_r - CNT_ONE;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_ONE;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_ONE;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries_r[wr_ptr_r] <= push_entry;
  end

  assign head         = entries_r[rd_ptr_r];
  assign q_stat.full  = (count_r == CNT_FULL);
  assign q_stat.empty = (count_r == '0);

endmodule

/* hdl/stt_back.sv */
// Back end: unroll queue entries into single results on the output register
module stt_back (
  input  logic               clk,
  input  logic               rst_n,
  input  stt_pkg::q_entry_t  head,
  input  stt_pkg::q_stat_t   q_stat,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output stt_pkg::out_item_t out_item
);

  logic               out_valid_r;
  stt_pkg::out_item_t out_item_r;
  logic               sub_r;
  logic               load;

  assign load = !q_stat.empty && (!out_valid_r || !out_stall);
  // Retire the entry once its last result is loaded
  assign pop  = load && (sub_r || !head.two);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sub_r       <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      sub_r       <= !sub_r && head.two;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_item_r <= sub_r ? head.res1 : head.res0;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* hdl/source_text_tokenizer.sv */
// Source text tokenizer top level: front end, entry queue and back end
//
// Takes source text one byte per transaction on the in_ channel; a transaction
// with end_of_text set flushes the pending token, emits END and restarts.
// Each token leaves on the out_ channel with kind, start offset, length and
// line; last_of_run marks the final result of one input byte. A byte causes
// zero, one or two results.
// A result passes through the entry queue and the output register before it is
// presented; a second result from the same byte follows behind the first.
// Throughput: one byte per cycle while in_stall is low. The output register loads
// one result per cycle while out_stall is low, so bytes that end a token and are
// a token themselves (two results) leave more slowly than they enter; the
// QUEUE_DEPTH-entry queue between front and back end absorbs this, and in_stall rises only when that queue is full.
// When the receiver raises out_stall the result holds on out_item and the
// queue fills behind it, then in_stall rises.
// Reset (rst_n low, synchronous) clears the scan state to idle, line 1 and
// offset 0, and empties the queue and output register.
`include "source_text_tokenizer_macros.svh"
module source_text_tokenizer #(
  parameter int OFFSET_BITS = 32,
  parameter int LENGTH_BITS = 16,
  parameter int LINE_BITS   = 24,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  stt_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output stt_pkg::out_item_t out_item
);

  logic              push;
  logic              pop;
  stt_pkg::q_entry_t push_entry;
  stt_pkg::q_entry_t head;
  stt_pkg::q_stat_t  q_stat;

  stt_front #(
    .OFFSET_BITS (OFFSET_BITS),
    .LENGTH_BITS (LENGTH_BITS),
    .LINE_BITS   (LINE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  stt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  stt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // End of text always leaves an entry queued
  `STT_ASSERT_NEXT(a_eot_queued, clk, rst_n, in_valid && !in_stall && in_item.end_of_text, !q_stat.empty)
  // END and ERROR always close the run of their byte
  `STT_ASSERT_SAME(a_end_last, clk, rst_n, out_valid && (out_item.token_kind == stt_pkg::KIND_END || out_item.token_kind == stt_pkg::KIND_ERROR), out_item.last_of_run)
  // Only a flushed number or identifier precedes another result of the same byte
  `STT_ASSERT_SAME(a_first_is_flush, clk, rst_n, out_valid && !out_item.last_of_run, out_item.token_kind == stt_pkg::KIND_INT || out_item.token_kind == stt_pkg::KIND_FLOAT || out_item.token_kind == stt_pkg::KIND_IDENT)

endmodule

/* verif/source_text_tokenizer_test.sv */
// Self-checking testbench for the source text tokenizer
`timescale 1ns / 1ps

module source_text_tokenizer_test;

  localparam int RANDOM_ITEMS = 1000;
  localparam int LONG_RUN     = 40;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 40;

  localparam logic [13*8-1:0] PUNCT_CHARS = {
    stt_pkg::CH_PLUS, stt_pkg::CH_MINUS, stt_pkg::CH_STAR, stt_pkg::CH_SLASH,
    stt_pkg::CH_EQUAL, stt_pkg::CH_LPAREN, stt_pkg::CH_RPAREN, stt_pkg::CH_LBRACE,
    stt_pkg::CH_RBRACE, stt_pkg::CH_PERIOD, stt_pkg::CH_COMMA, stt_pkg::CH_COLON,
    stt_pkg::CH_SEMI
  };

  typedef enum logic [1:0] {SCAN_IDLE, SCAN_NUMBER, SCAN_IDENT, SCAN_HALTED} scan_state_t;
  typedef enum int {PACE_STEADY, PACE_LIGHT, PACE_HEAVY} pace_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  stt_pkg::in_item_t  in_item;
  logic               out_valid;
  logic               out_stall;
  stt_pkg::out_item_t out_item;

  // scanner state mirrored by the predictor
  scan_state_t     scan;
  logic            has_period;
  stt_pkg::start_t run_start;
  stt_pkg::len_t   run_len;
  stt_pkg::line_t  line_cnt;
  stt_pkg::start_t next_offset;

  stt_pkg::out_item_t token_queue[$];
  stt_pkg::out_item_t want;
  int                 error_count = 0;
  int                 idle_cycles = 0;
  pace_t              pace = PACE_LIGHT;

  source_text_tokenizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void clear_scan();
    scan        = SCAN_IDLE;
    has_period  = 1'b0;
    run_start   = '0;
    run_len     = '0;
    line_cnt    = stt_pkg::line_t'(1);
    next_offset = '0;
  endfunction

  function automatic void add_token(stt_pkg::kind_t kind, stt_pkg::start_t start,
                                    stt_pkg::len_t len);
    stt_pkg::out_item_t tok;
    tok = '{token_kind: kind, token_start: start, token_length: len,
            line_number: line_cnt, last_of_run: 1'b0};
    token_queue.insert(token_queue.size(), tok);
  endfunction

  function automatic void flush_pending();
    if (scan == SCAN_NUMBER) begin
      add_token(has_period ? stt_pkg::KIND_FLOAT : stt_pkg::KIND_INT, run_start, run_len);
    end else if (scan == SCAN_IDENT) begin
      add_token(stt_pkg::KIND_IDENT, run_start, run_len);
    end
    scan       = SCAN_IDLE;
    has_period = 1'b0;
    run_len    = '0;
  endfunction

  function automatic void start_pending(scan_state_t mode);
    scan       = mode;
    has_period = 1'b0;
    run_start  = next_offset;
    run_len    = stt_pkg::len_t'(1);
  endfunction

  function automatic void grow_pending();
    if (run_len != '1) run_len++;
  endfunction

  // Work out the tokens that one accepted transaction produces
  function automatic void predict_tokens(logic [7:0] ch, logic eot);
    int                 first;
    stt_pkg::kind_t     pk;
    stt_pkg::out_item_t tail;
    first = token_queue.size();
    case (ch)
      stt_pkg::CH_PLUS:   pk = stt_pkg::KIND_PLUS;
      stt_pkg::CH_MINUS:  pk = stt_pkg::KIND_MINUS;
      stt_pkg::CH_STAR:   pk = stt_pkg::KIND_STAR;
      stt_pkg::CH_SLASH:  pk = stt_pkg::KIND_SLASH;
      stt_pkg::CH_EQUAL:  pk = stt_pkg::KIND_EQUAL;
      stt_pkg::CH_LPAREN: pk = stt_pkg::KIND_LPAREN;
      stt_pkg::CH_RPAREN: pk = stt_pkg::KIND_RPAREN;
      stt_pkg::CH_LBRACE: pk = stt_pkg::KIND_LBRACE;
      stt_pkg::CH_RBRACE: pk = stt_pkg::KIND_RBRACE;
      stt_pkg::CH_PERIOD: pk = stt_pkg::KIND_PERIOD;
      stt_pkg::CH_COMMA:  pk = stt_pkg::KIND_COMMA;
      stt_pkg::CH_COLON:  pk = stt_pkg::KIND_COLON;
      stt_pkg::CH_SEMI:   pk = stt_pkg::KIND_SEMI;
      default:            pk = stt_pkg::KIND_ERROR;
    endcase
    if (eot) begin
      if (scan != SCAN_HALTED) flush_pending();
      add_token(stt_pkg::KIND_END, next_offset, '0);
      clear_scan();
    end else begin
      if (scan != SCAN_HALTED) begin
        if ((ch >= stt_pkg::CH_LOW_A && ch <= stt_pkg::CH_LOW_Z) ||
            (ch >= stt_pkg::CH_UP_A && ch <= stt_pkg::CH_UP_Z)) begin
          if (scan == SCAN_IDENT) begin
            grow_pending();
          end else begin
            flush_pending();
            start_pending(SCAN_IDENT);
          end
        end else if (ch >= stt_pkg::CH_ZERO && ch <= stt_pkg::CH_NINE) begin
          if (scan == SCAN_IDLE) start_pending(SCAN_NUMBER);
          else grow_pending();
        end else if (ch == stt_pkg::CH_PERIOD && scan == SCAN_NUMBER) begin
          grow_pending();
          has_period = 1'b1;
        end else if (ch == stt_pkg::CH_SPACE || ch == stt_pkg::CH_TAB ||
                     ch == stt_pkg::CH_NEWLINE) begin
          // flushed token keeps the line it sat on
          flush_pending();
          if (ch == stt_pkg::CH_NEWLINE && line_cnt != '1) line_cnt++;
        end else if (pk == stt_pkg::KIND_ERROR) begin
          flush_pending();
          add_token(stt_pkg::KIND_ERROR, next_offset, stt_pkg::len_t'(1));
          scan = SCAN_HALTED;
        end else begin
          flush_pending();
          add_token(pk, next_offset, stt_pkg::len_t'(1));
        end
      end
      next_offset++;
    end
    if (token_queue.size() > first) begin
      tail = token_queue[token_queue.size() - 1];
      tail.last_of_run = 1'b1;
      token_queue[token_queue.size() - 1] = tail;
    end
  endfunction

  function automatic int draw_gap();
    case (pace)
      PACE_STEADY: return 0;
      PACE_LIGHT:  return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
      default:     return $urandom_range(0, 17);
    endcase
  endfunction

  task automatic send_byte(logic [7:0] ch, logic eot);
    int gap;
    gap = draw_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= '{in_byte: ch, end_of_text: eot};
    do @(posedge clk); while (in_stall);
    predict_tokens(ch, eot);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  function automatic logic [7:0] random_text_byte();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30 || (pick >= 95 && pick < 98)) begin
      return ($urandom_range(0, 1) ? stt_pkg::CH_LOW_A : stt_pkg::CH_UP_A) +
             8'($urandom_range(0, 25));
    end else if (pick < 55) begin
      return stt_pkg::CH_ZERO + 8'($urandom_range(0, 9));
    end else if (pick < 63) begin
      return stt_pkg::CH_PERIOD;
    end else if (pick < 75) begin
      return PUNCT_CHARS[$urandom_range(0, 12)*8 +: 8];
    end else if (pick < 88) begin
      return $urandom_range(0, 1) ? stt_pkg::CH_SPACE : stt_pkg::CH_TAB;
    end else if (pick < 95) begin
      return stt_pkg::CH_NEWLINE;
    end
    // any byte at all, mostly illegal ones
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic test_token_kinds();
    pace = PACE_LIGHT;
    // digit inside identifier, float, letter ending a number, every punctuation,
    // tab flush, newline, and end of text flushing a pending integer
    send_text("a1 9.5x\t+-*/=(){}.,:;\n7");
    send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic test_illegal_bytes();
    pace = PACE_HEAVY;
    send_text("k");
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h41, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_long_token();
    pace = PACE_STEADY;
    // one long identifier sent back to back
    repeat (LONG_RUN) send_byte(stt_pkg::CH_UP_A, 1'b0);
    send_byte(stt_pkg::CH_SPACE, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_random_text();
    int counted;
    int sent;
    counted = 0;
    sent = 0;
    while (counted < RANDOM_ITEMS) begin
      if (sent % 100 == 0) pace = pace_t'($urandom_range(0, 2));
      sent++;
      if (scan == SCAN_HALTED) begin
        // halted bytes are ignored; leave the halt soon
        if ($urandom_range(0, 2) == 0) begin
          send_byte(8'($urandom_range(0, 255)), 1'b1);
          counted++;
        end else begin
          send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
      end else begin
        if ($urandom_range(0, 99) < 2) send_byte(8'($urandom_range(0, 255)), 1'b1);
        else send_byte(random_text_byte(), 1'b0);
        counted++;
      end
    end
  endtask

  function automatic void check_field(string name, logic [31:0] expv, logic [31:0] actv);
    if (expv !== actv) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, expv, actv);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (token_queue.size() == 0) begin
        $display("%0t: unexpected token: expected none, actual kind %0d start %0d",
                 $time, out_item.token_kind, out_item.token_start);
        error_count++;
      end else begin
        want = token_queue.pop_front();
        check_field("token_kind", 32'(want.token_kind), 32'(out_item.token_kind));
        check_field("token_start", want.token_start, out_item.token_start);
        check_field("token_length", 32'(want.token_length), 32'(out_item.token_length));
        check_field("line_number", 32'(want.line_number), 32'(out_item.line_number));
        check_field("last_of_run", 32'(want.last_of_run), 32'(out_item.last_of_run));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: hold off a random number of cycles before taking each result
  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      hold = draw_gap();
      repeat (hold) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    clear_scan();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_token_kinds();
    test_illegal_bytes();
    test_long_token();
    test_random_text();

    @(negedge clk);
    in_valid <= 1'b0;
    while (token_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/stt_pkg.sv
hdl/stt_front.sv
hdl/stt_queue.sv
hdl/stt_back.sv
hdl/source_text_tokenizer.sv
verif/source_text_tokenizer_test.sv
